// ----- design/pptb_pkg.sv -----
// Shared types, codes and the status helper function of the pixel packet to bit-plane block.
package pptb_pkg;

    localparam int STRAND_LEDS_DEFAULT = 300;
    localparam int CHANNELS_DEFAULT    = 16;
    localparam int MAX_CHANNELS        = 16;
    localparam int ADDR_W              = 12;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic OP_BYTE   = 1'b0;
    localparam logic OP_RENDER = 1'b1;

    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_WORD   = 1'b1;

    localparam logic [2:0] ST_STORED      = 3'd0;
    localparam logic [2:0] ST_TOO_LONG    = 3'd1;
    localparam logic [2:0] ST_BAD_CHANNEL = 3'd2;
    localparam logic [2:0] ST_IGNORED     = 3'd3;
    localparam logic [2:0] ST_RANGE       = 3'd4;

    typedef struct packed {
        logic       opcode;
        logic [7:0] byte_in;
        logic [9:0] led_index;
    } req_t;

    typedef struct packed {
        logic        kind;
        logic [15:0] bit_word;
        logic [2:0]  status;
        logic        last;
    } rsp_t;

    typedef struct packed {
        logic                    wr_en;
        logic                    st_en;
        logic                    rn_en;
        logic [2:0]              status;
        logic [ADDR_W-1:0]       addr;
        logic [7:0]              data;
        logic [MAX_CHANNELS-1:0] mask;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_stat_t;

    function automatic logic [2:0] pkt_status(input logic [7:0] command,
                                              input logic [15:0] length,
                                              input logic [7:0] channel,
                                              input int body_max,
                                              input int channels);
        logic [2:0] st;
        if (command != 8'd0) st = ST_IGNORED;
        else if (32'(length) > body_max) st = ST_TOO_LONG;
        else if (32'(channel) > channels) st = ST_BAD_CHANNEL;
        else st = ST_STORED;
        return st;
    endfunction

endpackage

// ----- design/pptb_front.sv -----
// Front end: parses packet headers and turns stored body bytes, packet ends and render requests into back-end commands.
module pptb_front #(
    parameter int STRAND_LEDS = pptb_pkg::STRAND_LEDS_DEFAULT,
    parameter int CHANNELS    = pptb_pkg::CHANNELS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          accept,
    input  pptb_pkg::req_t req,
    output logic          push,
    output pptb_pkg::cmd_t cmd
);
    import pptb_pkg::*;

    localparam int BODY_MAX = STRAND_LEDS * 3;

    typedef enum logic [4:0] {
        H_CHAN = 5'b00001,
        H_CMD  = 5'b00010,
        H_LENH = 5'b00100,
        H_LENL = 5'b01000,
        H_BODY = 5'b10000
    } hdr_t;

    hdr_t        hdr_reg, hdr_next;
    logic [7:0]  chan_reg, chan_next;
    logic [7:0]  comm_reg, comm_next;
    logic [15:0] len_reg, len_next;
    logic [15:0] count_reg, count_next;

    always_comb
    begin
        logic [15:0] len_full;
        logic [16:0] count_inc;
        logic [2:0]  st;
        hdr_next   = hdr_reg;
        chan_next  = chan_reg;
        comm_next  = comm_reg;
        len_next   = len_reg;
        count_next = count_reg;
        push       = 1'b0;
        cmd        = '0;
        len_full   = {len_reg[15:8], req.byte_in};
        count_inc  = 17'(count_reg) + 17'd1;
        st         = pkt_status(comm_reg, len_reg, chan_reg, BODY_MAX, CHANNELS);
        if (accept)
        begin
            if (req.opcode == OP_RENDER)
            begin
                push = 1'b1;
                if (32'(req.led_index) >= STRAND_LEDS)
                begin
                    cmd.st_en  = 1'b1;
                    cmd.status = ST_RANGE;
                end
                else
                begin
                    cmd.rn_en = 1'b1;
                    cmd.addr  = ADDR_W'(req.led_index) + (ADDR_W'(req.led_index) << 1);
                end
            end
            else
            begin
                unique case (hdr_reg)
                    H_CHAN:
                    begin
                        chan_next = req.byte_in;
                        hdr_next  = H_CMD;
                    end
                    H_CMD:
                    begin
                        comm_next = req.byte_in;
                        hdr_next  = H_LENH;
                    end
                    H_LENH:
                    begin
                        len_next = {req.byte_in, 8'd0};
                        hdr_next = H_LENL;
                    end
                    H_LENL:
                    begin
                        len_next   = len_full;
                        count_next = 16'd0;
                        if (len_full == 16'd0)
                        begin
                            push       = 1'b1;
                            cmd.st_en  = 1'b1;
                            cmd.status = pkt_status(comm_reg, len_full, chan_reg,
                                                    BODY_MAX, CHANNELS);
                            hdr_next   = H_CHAN;
                        end
                        else
                        begin
                            hdr_next = H_BODY;
                        end
                    end
                    H_BODY:
                    begin
                        if (st == ST_STORED)
                        begin
                            push      = 1'b1;
                            cmd.wr_en = 1'b1;
                            cmd.addr  = count_reg[ADDR_W-1:0];
                            cmd.data  = req.byte_in;
                            if (chan_reg == 8'd0)
                                cmd.mask = MAX_CHANNELS'((32'd1 << CHANNELS) - 32'd1);
                            else
                                cmd.mask = MAX_CHANNELS'(1) << (chan_reg[4:0] - 5'd1);
                        end
                        count_next = count_inc[15:0];
                        if (count_inc >= 17'(len_reg))
                        begin
                            push       = 1'b1;
                            cmd.st_en  = 1'b1;
                            cmd.status = st;
                            hdr_next   = H_CHAN;
                        end
                    end
                    default:
                    begin
                        hdr_next = H_CHAN;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hdr_reg   <= H_CHAN;
            chan_reg  <= 8'd0;
            comm_reg  <= 8'd0;
            len_reg   <= 16'd0;
            count_reg <= 16'd0;
        end
        else
        begin
            hdr_reg   <= hdr_next;
            chan_reg  <= chan_next;
            comm_reg  <= comm_next;
            len_reg   <= len_next;
            count_reg <= count_next;
        end
    end

endmodule

// ----- design/pptb_queue.sv -----
// Short command queue between the front end and the back end.
module pptb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  pptb_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output pptb_pkg::cmd_t      head,
    output pptb_pkg::queue_stat_t stat
);
    import pptb_pkg::*;

    localparam int PW = $clog2(QUEUE_DEPTH);

    cmd_t          slots_reg [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PW:0]   fill_reg;

    assign head       = slots_reg[rd_ptr_reg];
    assign stat.full  = (fill_reg == (PW+1)'(QUEUE_DEPTH));
    assign stat.empty = (fill_reg == '0);

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_cmd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + PW'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + PW'(1);
            if (push && !pop)
                fill_reg <= fill_reg + (PW+1)'(1);
            else if (pop && !push)
                fill_reg <= fill_reg - (PW+1)'(1);
        end
    end

endmodule

// ----- design/pptb_back.sv -----
// Back end: owns the pixel store, executes commands and drives the result register.
module pptb_back #(
    parameter int STRAND_LEDS = pptb_pkg::STRAND_LEDS_DEFAULT,
    parameter int CHANNELS    = pptb_pkg::CHANNELS_DEFAULT
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  pptb_pkg::cmd_t         head,
    input  pptb_pkg::queue_stat_t  qstat,
    output logic                  pop,
    output logic                  clear_busy,
    output logic                  rsp_valid,
    input  logic                  rsp_stall,
    output pptb_pkg::rsp_t         rsp
);
    import pptb_pkg::*;

    localparam int BODY_MAX = STRAND_LEDS * 3;
    localparam int AW       = (BODY_MAX > 1) ? $clog2(BODY_MAX) : 1;
    localparam int RW       = CHANNELS * 8;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,
        S_IDLE  = 4'b0010,
        S_READ  = 4'b0100,
        S_EMIT  = 4'b1000
    } state_t;

    logic [RW-1:0] mem [BODY_MAX];

    state_t          state_reg, state_next;
    logic [AW-1:0]   clr_reg, clr_next;
    logic [AW-1:0]   base_reg, base_next;
    logic [1:0]      col_reg, col_next;
    logic [2:0]      bit_reg, bit_next;
    logic [RW-1:0]   row_reg;
    logic            out_valid_reg;
    rsp_t            out_reg;

    logic            out_free;
    logic            emit;
    rsp_t            emit_rsp;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [7:0]      mem_wdata;
    logic [MAX_CHANNELS-1:0] mem_mask;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;

    assign out_free   = !out_valid_reg || !rsp_stall;
    assign clear_busy = (state_reg == S_CLEAR);
    assign rsp_valid  = out_valid_reg;
    assign rsp        = out_reg;

    always_comb
    begin
        logic [MAX_CHANNELS-1:0] word;
        state_next = state_reg;
        clr_next   = clr_reg;
        base_next  = base_reg;
        col_next   = col_reg;
        bit_next   = bit_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        emit_rsp   = '0;
        mem_we     = 1'b0;
        mem_waddr  = head.addr[AW-1:0];
        mem_wdata  = head.data;
        mem_mask   = head.mask;
        rd_en      = 1'b0;
        rd_addr    = base_reg;
        word       = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
            word[ch] = row_reg[ch*8 + 32'(bit_reg)];
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = 8'd0;
                mem_mask  = '1;
                clr_next  = clr_reg + AW'(1);
                if (32'(clr_reg) == BODY_MAX - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (!qstat.empty && (out_free || !head.st_en))
                begin
                    pop    = 1'b1;
                    mem_we = head.wr_en;
                    if (head.st_en)
                    begin
                        emit            = 1'b1;
                        emit_rsp.kind   = KIND_STATUS;
                        emit_rsp.status = head.status;
                        emit_rsp.last   = 1'b1;
                    end
                    if (head.rn_en)
                    begin
                        base_next  = head.addr[AW-1:0];
                        col_next   = 2'd0;
                        state_next = S_READ;
                    end
                end
            end
            S_READ:
            begin
                rd_en = 1'b1;
                unique case (col_reg)
                    2'd0:    rd_addr = base_reg + AW'(1);
                    2'd1:    rd_addr = base_reg;
                    default: rd_addr = base_reg + AW'(2);
                endcase
                bit_next   = 3'd7;
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    emit              = 1'b1;
                    emit_rsp.kind     = KIND_WORD;
                    emit_rsp.bit_word = word;
                    emit_rsp.status   = ST_STORED;
                    emit_rsp.last     = (col_reg == 2'd2) && (bit_reg == 3'd0);
                    bit_next          = bit_reg - 3'd1;
                    if (bit_reg == 3'd0)
                    begin
                        if (col_reg == 2'd2)
                        begin
                            state_next = S_IDLE;
                        end
                        else
                        begin
                            col_next   = col_reg + 2'd1;
                            state_next = S_READ;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            for (int l = 0; l < CHANNELS; l++)
            begin
                if (mem_mask[l])
                    mem[mem_waddr][l*8 +: 8] <= mem_wdata;
            end
        end
        if (rd_en)
            row_reg <= mem[rd_addr];
        if (emit)
            out_reg <= emit_rsp;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            base_reg      <= '0;
            col_reg       <= 2'd0;
            bit_reg       <= 3'd7;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            clr_reg   <= clr_next;
            base_reg  <= base_next;
            col_reg   <= col_next;
            bit_reg   <= bit_next;
            if (emit)
                out_valid_reg <= 1'b1;
            else if (!rsp_stall)
                out_valid_reg <= 1'b0;
        end
    end

endmodule

// ----- design/pixel_packet_to_bitplanes.sv -----
// Top level of the pixel packet receiver with bit-plane renderer.
//
//   channel | direction | payload        | handshake
//   req     | in        | pptb_pkg::req_t | req_valid / req_stall
//   rsp     | out       | pptb_pkg::rsp_t | rsp_valid / rsp_stall
//
// A stream byte is taken every cycle while req_stall is low; a body byte passes through the
// command queue before it is written to the store.
// A render holds the back end for the pop, then one store read per colour, each
// followed by eight words.
// After reset a clearing pass writes zeros to all 3*STRAND_LEDS rows, one row a cycle,
// and holds req_stall high for those cycles.
// A stalled result holds the back end at its next result (store writes still proceed); the
// four-entry command queue keeps the front taking bytes until it fills.
module pixel_packet_to_bitplanes #(
    parameter int STRAND_LEDS = pptb_pkg::STRAND_LEDS_DEFAULT,
    parameter int CHANNELS    = pptb_pkg::CHANNELS_DEFAULT
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  pptb_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output pptb_pkg::rsp_t rsp
);
    import pptb_pkg::*;

    logic        accept;
    logic        push;
    cmd_t        push_cmd;
    cmd_t        head;
    queue_stat_t qstat;
    logic        pop;
    logic        clear_busy;

    assign req_stall = qstat.full || clear_busy;
    assign accept    = req_valid && !req_stall;

    pptb_front #(
        .STRAND_LEDS(STRAND_LEDS),
        .CHANNELS(CHANNELS)
    ) u_front (
        .clk(clk),
        .rst_n(rst_n),
        .accept(accept),
        .req(req),
        .push(push),
        .cmd(push_cmd)
    );

    pptb_queue u_queue (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .push_cmd(push_cmd),
        .pop(pop),
        .head(head),
        .stat(qstat)
    );

    pptb_back #(
        .STRAND_LEDS(STRAND_LEDS),
        .CHANNELS(CHANNELS)
    ) u_back (
        .clk(clk),
        .rst_n(rst_n),
        .head(head),
        .qstat(qstat),
        .pop(pop),
        .clear_busy(clear_busy),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp(rsp)
    );

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !qstat.full)
        else $error("Command queue written while full.");

    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !qstat.empty)
        else $error("Command queue read while empty.");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind == KIND_STATUS) |-> (rsp.last && rsp.bit_word == 16'd0))
        else $error("Status transfer without last or with a nonzero word.");

endmodule
